### hw/rtl/csu_pkg.sv
// ----------------------------------------------------------------------------
// csu_pkg
// shared types, codes and default sizes for the counting semaphore unit
// ----------------------------------------------------------------------------
package csu_pkg;

  // default sizes, handed to the top level parameters
  localparam int DEF_NUM_SEMS    = 64;
  localparam int DEF_NUM_THREADS = 128;
  localparam int DEF_COUNT_LIMIT = 65536;

  // fixed field widths
  localparam int OPC_W       = 2;
  localparam int SLOT_PORT_W = 6;
  localparam int CNT_W       = 17;
  localparam int TID_PORT_W  = 7;
  localparam int STATUS_W    = 3;

  typedef enum logic [OPC_W-1:0] {
    OP_INIT    = 2'd0,
    OP_DESTROY = 2'd1,
    OP_WAIT    = 2'd2,
    OP_POST    = 2'd3
  } csu_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_NOT_SUPPORTED = 3'd1,
    ST_INVALID       = 3'd2,
    ST_OVERFLOW      = 3'd3,
    ST_FULL          = 3'd4
  } csu_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK
  } csu_state_t;

  // one entry of the slot memory
  typedef struct packed {
    logic [CNT_W-1:0]      count;
    logic [TID_PORT_W-1:0] head;
    logic [TID_PORT_W-1:0] tail;
  } csu_slot_word_t;

endpackage

### hw/rtl/counting_semaphore_unit_top.sv
// ----------------------------------------------------------------------------
// counting_semaphore_unit_top
// bank of counting semaphores, each with a fifo wait queue of thread ids
// ----------------------------------------------------------------------------
//
// channel   direction  handshake           payload
// request   in         start & !busy       opcode sem_slot shared_request
//                                          initial_value thread_id
// result    out        done, one cycle     status new_handle blocked
//                                          woke_valid woke_thread
//
// a request runs the slot memory read, then the decision and write back; a
// post that wakes a waiter while others stay queued adds a link step, the
// read of the wait link memory at the old head
// busy is high while a request is in flight; the result beat shows on done
// the cycle after the write back and a new request may start in that cycle
// rst is synchronous: slots and queue flags clear at once, no clearing pass
// the receiver cannot stall, so done is never held
//
module counting_semaphore_unit_top #(
  parameter int NUM_SEMS    = csu_pkg::DEF_NUM_SEMS,
  parameter int NUM_THREADS = csu_pkg::DEF_NUM_THREADS,
  parameter int COUNT_LIMIT = csu_pkg::DEF_COUNT_LIMIT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [csu_pkg::OPC_W-1:0]       opcode,
  input  logic [csu_pkg::SLOT_PORT_W-1:0] sem_slot,
  input  logic                            shared_request,
  input  logic [csu_pkg::CNT_W-1:0]       initial_value,
  input  logic [csu_pkg::TID_PORT_W-1:0]  thread_id,
  output logic                            done,
  output logic [csu_pkg::STATUS_W-1:0]    status,
  output logic [csu_pkg::SLOT_PORT_W-1:0] new_handle,
  output logic                            blocked,
  output logic                            woke_valid,
  output logic [csu_pkg::TID_PORT_W-1:0]  woke_thread
);

  import csu_pkg::*;

  localparam int SLOT_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int TID_W  = $clog2(NUM_THREADS);
  localparam int WORD_W = $bits(csu_slot_word_t);

  csu_state_t state, state_next;

  // request registers
  csu_op_t                 req_op;
  logic [SLOT_PORT_W-1:0]  req_slot;
  logic                    req_shared;
  logic [CNT_W-1:0]        req_value;
  logic [TID_PORT_W-1:0]   req_tid;

  // per-slot flags in flops
  logic [NUM_SEMS-1:0] slot_in_use;
  logic [NUM_SEMS-1:0] queue_nonempty;

  logic              accept;
  logic [SLOT_W-1:0] slot_idx;
  logic              slot_known;
  logic [SLOT_W-1:0] free_idx;
  logic              free_any;

  // slot memory ports
  csu_slot_word_t    rd_word;
  logic [WORD_W-1:0] rd_bits;
  logic              sw_we;
  logic [SLOT_W-1:0] sw_addr;
  csu_slot_word_t    sw_data;

  // wait link memory ports
  logic                  lk_we;
  logic [TID_W-1:0]      lk_waddr;
  logic [TID_PORT_W-1:0] lk_wdata;
  logic                  lk_re;
  logic [TID_W-1:0]      lk_raddr;
  logic [TID_PORT_W-1:0] lk_rdata;

  // decisions of the execute step
  logic              finish;
  logic              go_link;
  logic              use_set;
  logic              use_clr;
  logic              ne_set;
  logic              ne_clr;
  logic [SLOT_W-1:0] flag_idx;

  csu_status_t           status_next;
  logic [SLOT_PORT_W-1:0] handle_next;
  logic                  blocked_next;
  logic                  woke_valid_next;
  logic [TID_PORT_W-1:0] woke_thread_next;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign rd_word = csu_slot_word_t'(rd_bits);

  // the request slot is known when it is inside the bank and allocated
  assign slot_idx   = SLOT_W'(req_slot);
  assign slot_known = (32'(req_slot) < NUM_SEMS) && slot_in_use[slot_idx];

  csu_free_find #(
    .NUM_SEMS (NUM_SEMS)
  ) u_free_find (
    .clk      (clk),
    .used     (slot_in_use),
    .free_idx (free_idx),
    .free_any (free_any)
  );

  // count, head and tail of every slot; read at accept, written back after
  csu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_SEMS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (sw_we),
    .waddr (sw_addr),
    .wdata (sw_data),
    .re    (accept),
    .raddr (SLOT_W'(sem_slot)),
    .rdata (rd_bits)
  );

  // next waiter behind each queued thread
  csu_ram #(
    .WIDTH (TID_PORT_W),
    .DEPTH (NUM_THREADS)
  ) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  // capture the request beat
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op     <= csu_op_t'(opcode);
      req_slot   <= sem_slot;
      req_shared <= shared_request;
      req_value  <= initial_value;
      req_tid    <= thread_id;
    end
  end

  // execute step: decide on the read data and build the write back
  always_comb begin
    status_next      = ST_OK;
    handle_next      = '0;
    blocked_next     = 1'b0;
    woke_valid_next  = 1'b0;
    woke_thread_next = '0;
    sw_we    = 1'b0;
    sw_addr  = slot_idx;
    sw_data  = rd_word;
    lk_we    = 1'b0;
    lk_waddr = TID_W'(rd_word.tail);
    lk_wdata = req_tid;
    lk_re    = 1'b0;
    lk_raddr = TID_W'(rd_word.head);
    use_set  = 1'b0;
    use_clr  = 1'b0;
    ne_set   = 1'b0;
    ne_clr   = 1'b0;
    flag_idx = slot_idx;
    finish   = 1'b0;
    go_link  = 1'b0;
    unique case (state)
      S_EXEC: begin
        finish = 1'b1;
        priority if (req_op == OP_INIT) begin
          flag_idx = free_idx;
          sw_addr  = free_idx;
          priority if (req_shared) begin
            status_next = ST_NOT_SUPPORTED;
          end else if (32'(req_value) > COUNT_LIMIT) begin
            status_next = ST_INVALID;
          end else if (!free_any) begin
            status_next = ST_FULL;
          end else begin
            handle_next   = SLOT_PORT_W'(free_idx);
            use_set       = 1'b1;
            ne_clr        = 1'b1;
            sw_we         = 1'b1;
            sw_data.count = req_value;
          end
        end else if (!slot_known) begin
          status_next = ST_INVALID;
        end else if (req_op == OP_DESTROY) begin
          use_clr = 1'b1;
          ne_clr  = 1'b1;
        end else if (req_op == OP_WAIT) begin
          priority if (rd_word.count != '0) begin
            sw_we         = 1'b1;
            sw_data.count = rd_word.count - CNT_W'(1);
          end else if (32'(req_tid) >= NUM_THREADS) begin
            status_next = ST_INVALID;
          end else begin
            // append the caller behind the tail, or start the queue
            if (queue_nonempty[slot_idx]) begin
              lk_we = 1'b1;
            end else begin
              sw_data.head = req_tid;
              ne_set       = 1'b1;
            end
            sw_data.tail = req_tid;
            sw_we        = 1'b1;
            blocked_next = 1'b1;
          end
        end else begin
          // post
          priority if (rd_word.count != '0) begin
            if (32'(rd_word.count) >= COUNT_LIMIT) begin
              status_next = ST_OVERFLOW;
            end else begin
              sw_we         = 1'b1;
              sw_data.count = rd_word.count + CNT_W'(1);
            end
          end else if (queue_nonempty[slot_idx]) begin
            woke_valid_next  = 1'b1;
            woke_thread_next = rd_word.head;
            if (rd_word.head == rd_word.tail) begin
              ne_clr = 1'b1;
            end else begin
              // fetch the successor of the head before writing back
              finish  = 1'b0;
              go_link = 1'b1;
              lk_re   = 1'b1;
            end
          end else begin
            sw_we         = 1'b1;
            sw_data.count = CNT_W'(1);
          end
        end
      end
      S_LINK: begin
        finish           = 1'b1;
        sw_we            = 1'b1;
        sw_data.head     = lk_rdata;
        woke_valid_next  = 1'b1;
        woke_thread_next = rd_word.head;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = go_link ? S_LINK : S_IDLE;
      end
      S_LINK: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // slot and queue flags
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_in_use    <= '0;
      queue_nonempty <= '0;
    end else begin
      if (use_set) begin
        slot_in_use[flag_idx] <= 1'b1;
      end else if (use_clr) begin
        slot_in_use[flag_idx] <= 1'b0;
      end
      if (ne_set) begin
        queue_nonempty[flag_idx] <= 1'b1;
      end else if (ne_clr) begin
        queue_nonempty[flag_idx] <= 1'b0;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status      <= status_next;
      new_handle  <= handle_next;
      blocked     <= blocked_next;
      woke_valid  <= woke_valid_next;
      woke_thread <= woke_thread_next;
    end
  end

`ifndef SYNTH
  // a result beat always follows an execute or link step
  a_done_after_work : assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_EXEC || $past(state) == S_LINK))
    else $error("result beat without a request in flight");

  // an accepted request goes straight to execute
  a_accept_exec : assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted request did not reach execute");

  // the link step only follows an execute step
  a_link_from_exec : assert property (@(posedge clk) disable iff (rst)
    state == S_LINK |-> $past(state) == S_EXEC)
    else $error("link step entered without execute");

  // a wake is always a clean post
  a_wake_ok : assert property (@(posedge clk) disable iff (rst)
    done && woke_valid |-> (status == ST_OK && req_op == OP_POST))
    else $error("wake reported outside a successful post");

  // only a wait can block its caller
  a_block_wait : assert property (@(posedge clk) disable iff (rst)
    done && blocked |-> req_op == OP_WAIT)
    else $error("blocked reported outside a wait");
`endif

endmodule

### hw/rtl/csu_ram.sv
// ----------------------------------------------------------------------------
// csu_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module csu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/csu_free_find.sv
// ----------------------------------------------------------------------------
// csu_free_find
// registered search for the lowest free semaphore slot
// ----------------------------------------------------------------------------
module csu_free_find #(
  parameter int NUM_SEMS = 64
) (
  input  logic                                          clk,
  input  logic [NUM_SEMS-1:0]                           used,
  output logic [(NUM_SEMS > 1 ? $clog2(NUM_SEMS) : 1)-1:0] free_idx,
  output logic                                          free_any
);

  localparam int SLOT_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

  logic [NUM_SEMS-1:0] lowest;
  logic [SLOT_W-1:0]   idx;

  // lowest clear bit of used as a one-hot word
  assign lowest = ~used & (used + NUM_SEMS'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < NUM_SEMS; i++) begin
      if (lowest[i]) begin
        idx = idx | SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    free_idx <= idx;
    free_any <= ~&used;
  end

endmodule

### test/csu_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csu_result_checker
// watches the request and result channels of the semaphore unit, keeps its
// own copy of the slot, count and wait-queue state, and checks every result
// ----------------------------------------------------------------------------
module csu_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [csu_pkg::OPC_W-1:0]       opcode,
  input  logic [csu_pkg::SLOT_PORT_W-1:0] sem_slot,
  input  logic                            shared_request,
  input  logic [csu_pkg::CNT_W-1:0]       initial_value,
  input  logic [csu_pkg::TID_PORT_W-1:0]  thread_id,
  input  logic                            done,
  input  logic [csu_pkg::STATUS_W-1:0]    status,
  input  logic [csu_pkg::SLOT_PORT_W-1:0] new_handle,
  input  logic                            blocked,
  input  logic                            woke_valid,
  input  logic [csu_pkg::TID_PORT_W-1:0]  woke_thread,
  output int                              fail_count,
  output int                              outstanding,
  output int                              beats_checked,
  output int                              wake_count,
  output int                              block_count,
  output int                              full_count,
  output int                              overflow_count
);

  import csu_pkg::*;

  typedef struct packed {
    csu_status_t            st;
    logic [SLOT_PORT_W-1:0] handle;
    logic                   blocked;
    logic                   woke;
    logic [TID_PORT_W-1:0]  woke_tid;
  } sem_result_t;

  // shadow of the semaphore bank
  bit                   slot_taken [DEF_NUM_SEMS];
  bit [CNT_W-1:0]       sem_level  [DEF_NUM_SEMS];
  bit                   waiters_on [DEF_NUM_SEMS];
  bit [TID_PORT_W-1:0]  waiter_first [DEF_NUM_SEMS];
  bit [TID_PORT_W-1:0]  waiter_last  [DEF_NUM_SEMS];
  bit [TID_PORT_W-1:0]  waiter_link  [DEF_NUM_THREADS];

  sem_result_t expected_results[$];

  function automatic sem_result_t predict_semaphore_op(
    csu_op_t op, logic [SLOT_PORT_W-1:0] slot, logic shr,
    logic [CNT_W-1:0] val, logic [TID_PORT_W-1:0] tid);
    sem_result_t r;
    int i;
    r = '{st: ST_OK, handle: '0, blocked: 1'b0, woke: 1'b0, woke_tid: '0};
    if (op == OP_INIT) begin
      if (shr) begin
        r.st = ST_NOT_SUPPORTED;
      end else if (val > DEF_COUNT_LIMIT) begin
        r.st = ST_INVALID;
      end else begin
        r.st = ST_FULL;
        for (i = 0; i < DEF_NUM_SEMS; i++) begin
          if (!slot_taken[i]) begin
            slot_taken[i] = 1'b1;
            sem_level[i]  = val;
            waiters_on[i] = 1'b0;
            r.st          = ST_OK;
            r.handle      = i[SLOT_PORT_W-1:0];
            break;
          end
        end
      end
    end else if (slot >= DEF_NUM_SEMS || !slot_taken[slot]) begin
      r.st = ST_INVALID;
    end else if (op == OP_DESTROY) begin
      // queued waiters are simply dropped
      slot_taken[slot] = 1'b0;
      waiters_on[slot] = 1'b0;
    end else if (op == OP_WAIT) begin
      if (sem_level[slot] > 0) begin
        sem_level[slot]--;
      end else if (tid >= DEF_NUM_THREADS) begin
        r.st = ST_INVALID;
      end else begin
        // a thread queued twice just gets its link overwritten
        if (waiters_on[slot]) begin
          waiter_link[waiter_last[slot]] = tid;
        end else begin
          waiter_first[slot] = tid;
          waiters_on[slot]   = 1'b1;
        end
        waiter_last[slot] = tid;
        r.blocked = 1'b1;
      end
    end else begin
      if (sem_level[slot] > 0) begin
        if (int'(sem_level[slot]) + 1 > DEF_COUNT_LIMIT) r.st = ST_OVERFLOW;
        else sem_level[slot]++;
      end else if (waiters_on[slot]) begin
        // hand the unit straight to the oldest waiter
        r.woke     = 1'b1;
        r.woke_tid = waiter_first[slot];
        if (waiter_first[slot] == waiter_last[slot]) waiters_on[slot] = 1'b0;
        else waiter_first[slot] = waiter_link[waiter_first[slot]];
      end else begin
        sem_level[slot] = CNT_W'(1);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    sem_result_t want;
    if (rst) begin
      for (int i = 0; i < DEF_NUM_SEMS; i++) begin
        slot_taken[i] = 1'b0;
        sem_level[i]  = '0;
        waiters_on[i] = 1'b0;
      end
      expected_results.delete();
      fail_count     = 0;
      beats_checked  = 0;
      wake_count     = 0;
      block_count    = 0;
      full_count     = 0;
      overflow_count = 0;
    end else begin
      // the result of an older request comes before any new acceptance
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no request outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          beats_checked++;
          if (status !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, status);
            fail_count++;
          end
          if (new_handle !== want.handle) begin
            $error("new_handle: expected %0d, actual %0d", want.handle, new_handle);
            fail_count++;
          end
          if (blocked !== want.blocked) begin
            $error("blocked: expected %0d, actual %0d", want.blocked, blocked);
            fail_count++;
          end
          if (woke_valid !== want.woke) begin
            $error("woke_valid: expected %0d, actual %0d", want.woke, woke_valid);
            fail_count++;
          end
          if (woke_thread !== want.woke_tid) begin
            $error("woke_thread: expected %0d, actual %0d", want.woke_tid, woke_thread);
            fail_count++;
          end
          if (want.woke) wake_count++;
          if (want.blocked) block_count++;
          if (want.st == ST_FULL) full_count++;
          if (want.st == ST_OVERFLOW) overflow_count++;
        end
      end
      if (start && !busy) begin
        expected_results.push_back(predict_semaphore_op(csu_op_t'(opcode), sem_slot,
                                                        shared_request, initial_value,
                                                        thread_id));
      end
    end
    outstanding = expected_results.size();
  end

endmodule

### test/counting_semaphore_unit_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// counting_semaphore_unit_top_tb
// drives semaphore requests in random bursts (directed corner cases first,
// then fill, churn and drain mixes) and gives the verdict from the checker
// ----------------------------------------------------------------------------
module counting_semaphore_unit_top_tb;
  import csu_pkg::*;

  localparam int TOTAL_REQUESTS = 1900;

  // random traffic mixes: fill grows the bank toward full, churn works the
  // counts and wait queues, drain frees slots again
  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} traffic_mix_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [OPC_W-1:0]       opcode;
  logic [SLOT_PORT_W-1:0] sem_slot;
  logic                   shared_request;
  logic [CNT_W-1:0]       initial_value;
  logic [TID_PORT_W-1:0]  thread_id;
  logic                   done;
  logic [STATUS_W-1:0]    status;
  logic [SLOT_PORT_W-1:0] new_handle;
  logic                   blocked;
  logic                   woke_valid;
  logic [TID_PORT_W-1:0]  woke_thread;

  int fail_count, outstanding, beats_checked;
  int wake_count, block_count, full_count, overflow_count;
  int sent_count;

  counting_semaphore_unit_top DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .sem_slot       (sem_slot),
    .shared_request (shared_request),
    .initial_value  (initial_value),
    .thread_id      (thread_id),
    .done           (done),
    .status         (status),
    .new_handle     (new_handle),
    .blocked        (blocked),
    .woke_valid     (woke_valid),
    .woke_thread    (woke_thread)
  );

  csu_result_checker chk (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .sem_slot       (sem_slot),
    .shared_request (shared_request),
    .initial_value  (initial_value),
    .thread_id      (thread_id),
    .done           (done),
    .status         (status),
    .new_handle     (new_handle),
    .blocked        (blocked),
    .woke_valid     (woke_valid),
    .woke_thread    (woke_thread),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .beats_checked  (beats_checked),
    .wake_count     (wake_count),
    .block_count    (block_count),
    .full_count     (full_count),
    .overflow_count (overflow_count)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the unit hangs or a result never shows up
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // one request beat: called at a falling edge, returns at the falling edge
  // after acceptance with start still high so a burst can go on seamlessly
  task automatic send_request(csu_op_t op, logic [SLOT_PORT_W-1:0] slot, logic shr,
                              logic [CNT_W-1:0] val, logic [TID_PORT_W-1:0] tid);
    start          <= 1'b1;
    opcode         <= op;
    sem_slot       <= slot;
    shared_request <= shr;
    initial_value  <= val;
    thread_id      <= tid;
    // busy is sampled before the edge updates it, same as the checker sees it
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent_count++;
  endtask

  // sender gap: start low, payload wiggles meanwhile
  task automatic idle_gap(int cycles);
    start          <= 1'b0;
    opcode         <= OPC_W'($urandom);
    sem_slot       <= SLOT_PORT_W'($urandom);
    shared_request <= 1'($urandom);
    initial_value  <= CNT_W'($urandom);
    thread_id      <= TID_PORT_W'($urandom);
    repeat (cycles) @(negedge clk);
  endtask

  // start values lean on zero and small counts so waits actually block,
  // with the limit, just below it and illegal values mixed in
  function automatic logic [CNT_W-1:0] pick_start_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return '0;
    if (roll < 60) return CNT_W'($urandom_range(1, 4));
    if (roll < 68) return CNT_W'(DEF_COUNT_LIMIT);
    if (roll < 73) return CNT_W'(DEF_COUNT_LIMIT - 1);
    if (roll < 80) return CNT_W'($urandom_range(DEF_COUNT_LIMIT + 1, (1 << CNT_W) - 1));
    return CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
  endfunction

  task automatic random_request(traffic_mix_t mix, int span);
    int roll, init_w, destroy_w, wait_w;
    csu_op_t op;
    logic [SLOT_PORT_W-1:0] slot;
    logic [TID_PORT_W-1:0] tid;
    logic shr;
    case (mix)
      MIX_FILL:  begin init_w = 80; destroy_w = 4;  wait_w = 8;  end
      MIX_DRAIN: begin init_w = 10; destroy_w = 40; wait_w = 25; end
      default:   begin init_w = 10; destroy_w = 5;  wait_w = 45; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < init_w) op = OP_INIT;
    else if (roll < init_w + destroy_w) op = OP_DESTROY;
    else if (roll < init_w + destroy_w + wait_w) op = OP_WAIT;
    else op = OP_POST;
    // handles are handed out lowest first, so most traffic goes to low slots
    if ($urandom_range(0, 99) < 85) slot = SLOT_PORT_W'($urandom_range(0, span));
    else slot = SLOT_PORT_W'($urandom);
    // a small pool of threads makes repeated waits by the same thread common
    if ($urandom_range(0, 99) < 60) tid = TID_PORT_W'($urandom_range(0, 15));
    else tid = TID_PORT_W'($urandom);
    shr = ($urandom_range(0, 99) < 5);
    send_request(op, slot, shr, pick_start_count(), tid);
  endtask

  initial begin
    traffic_mix_t mix;
    int seg_left, span, burst;

    sent_count     = 0;
    rst            = 1'b1;
    start          = 1'b0;
    opcode         = OP_INIT;
    sem_slot       = '0;
    shared_request = 1'b0;
    initial_value  = '0;
    thread_id      = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed corner cases ----
    // shared init is refused before the value is looked at
    send_request(OP_INIT, 6'd0, 1'b1, 17'h1FFFF, 7'd0);
    // start counts above the limit
    send_request(OP_INIT, 6'd0, 1'b0, CNT_W'(DEF_COUNT_LIMIT + 1), 7'd0);
    send_request(OP_INIT, 6'd63, 1'b0, 17'h1FFFF, 7'd127);
    // slot 0 at zero, slot 1 at the limit
    send_request(OP_INIT, 6'd63, 1'b0, 17'd0, 7'd0);
    send_request(OP_INIT, 6'd0, 1'b0, CNT_W'(DEF_COUNT_LIMIT), 7'd0);
    // post at the limit overflows and keeps the count
    send_request(OP_POST, 6'd1, 1'b0, 17'd0, 7'd0);
    send_request(OP_WAIT, 6'd1, 1'b0, 17'd0, 7'd5);
    send_request(OP_POST, 6'd1, 1'b0, 17'd0, 7'd0);
    idle_gap(3);
    // three waiters on slot 0, one thread queued twice
    send_request(OP_WAIT, 6'd0, 1'b0, 17'd0, 7'd127);
    send_request(OP_WAIT, 6'd0, 1'b0, 17'd0, 7'd0);
    send_request(OP_WAIT, 6'd0, 1'b0, 17'd0, 7'd127);
    // first post wakes 127 and empties the queue, the rest raise the count
    send_request(OP_POST, 6'd0, 1'b0, 17'd0, 7'd0);
    send_request(OP_POST, 6'd0, 1'b0, 17'd0, 7'd0);
    send_request(OP_POST, 6'd0, 1'b0, 17'd0, 7'd0);
    send_request(OP_POST, 6'd0, 1'b0, 17'd0, 7'd0);
    send_request(OP_WAIT, 6'd0, 1'b0, 17'd0, 7'd85);
    idle_gap(1);
    // destroy slot 0 while it still holds a count, then hit the dead slot
    send_request(OP_WAIT, 6'd0, 1'b0, 17'd0, 7'd42);
    send_request(OP_DESTROY, 6'd0, 1'b0, 17'd0, 7'd0);
    send_request(OP_WAIT, 6'd0, 1'b0, 17'd0, 7'd42);
    send_request(OP_POST, 6'd0, 1'b0, 17'd0, 7'd0);
    // unknown slots
    send_request(OP_POST, 6'd63, 1'b0, 17'd0, 7'd0);
    send_request(OP_DESTROY, 6'd63, 1'b1, 17'h1FFFF, 7'd127);
    // freed slot 0 is handed out again
    send_request(OP_INIT, 6'd0, 1'b0, 17'd1, 7'd0);
    idle_gap(2);

    // ---- random part: bursts over a sequence of traffic mixes ----
    // the first segment fills the bank so full shows up early
    mix      = MIX_FILL;
    seg_left = 90;
    span     = 15;
    while (sent_count < TOTAL_REQUESTS) begin
      if (seg_left <= 0) begin
        burst = $urandom_range(0, 99);
        if (burst < 25) mix = MIX_FILL;
        else if (burst < 80) mix = MIX_CHURN;
        else mix = MIX_DRAIN;
        seg_left = $urandom_range(40, 150);
        span     = $urandom_range(3, 15);
      end
      burst = $urandom_range(1, 24);
      while (burst > 0 && sent_count < TOTAL_REQUESTS) begin
        random_request(mix, span);
        burst--;
        seg_left--;
      end
      // about a third of the bursts run straight into the next one
      if ($urandom_range(0, 99) >= 30) idle_gap($urandom_range(1, 8));
    end
    start <= 1'b0;

    // drain: wait until every expected result has come back
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("run: %0d requests, %0d results checked, %0d blocked waits, %0d wakeups",
             sent_count, beats_checked, block_count, wake_count);
    $display("run: %0d full inits, %0d overflowing posts", full_count, overflow_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/csu_pkg.sv
hw/rtl/csu_ram.sv
hw/rtl/csu_free_find.sv
hw/rtl/counting_semaphore_unit_top.sv
test/csu_result_checker.sv
test/counting_semaphore_unit_top_tb.sv
